@@ rtl/core/vwm_pkg.sv @@
// Shared types, codes and constants for the vehicle warning monitor.
// Used by vehicle_warning_monitor; no dependencies.
package vwm_pkg;

  // Channel layout
  localparam int NUM_CHANNELS = 9;
  localparam int CH_IDX_W     = 4;
  localparam logic [CH_IDX_W-1:0] TOP_NONE = CH_IDX_W'(NUM_CHANNELS);

  localparam int CH_LINK  = 0;
  localparam int CH_MIL   = 1;
  localparam int CH_ENG   = 2;
  localparam int CH_TRANS = 3;
  localparam int CH_BATT  = 4;
  localparam int CH_ICE   = 5;
  localparam int CH_GPS   = 6;
  localparam int CH_SERV  = 7;
  localparam int CH_FUEL  = 8;

  // Status flag bit positions
  localparam int ST_LINK_UP     = 0;
  localparam int ST_MIL_ON      = 1;
  localparam int ST_TRANS_PRES  = 2;
  localparam int ST_GPS_FIX     = 3;
  localparam int ST_BATT_VALID  = 4;
  localparam int ST_TRANS_VALID = 5;
  localparam int ST_OUT_VALID   = 6;

  // Feature enable bit positions
  localparam int FE_ICE  = 0;
  localparam int FE_GPS  = 1;
  localparam int FE_FUEL = 2;

  // Item codes
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_HIDE  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REALERT    = 3'd0,
    REG_ENG_LIMIT  = 3'd1,
    REG_TRANS_LIM  = 3'd2,
    REG_BATT_HIGH  = 3'd3,
    REG_BATT_LOW   = 3'd4,
    REG_OUT_LIMIT  = 3'd5,
    REG_FUEL_LIMIT = 3'd6,
    REG_FEATURES   = 3'd7
  } cfg_reg_t;

  // Register reset values
  localparam logic [7:0]  RST_REALERT    = 8'd5;
  localparam logic [7:0]  RST_ENG_LIMIT  = 8'd105;
  localparam logic [7:0]  RST_TRANS_LIM  = 8'd110;
  localparam logic [14:0] RST_BATT_HIGH  = 15'd14800;
  localparam logic [14:0] RST_BATT_LOW   = 15'd11800;
  localparam logic [6:0]  RST_OUT_LIMIT  = 7'd3;
  localparam logic [9:0]  RST_FUEL_LIMIT = 10'd10;
  localparam logic [2:0]  RST_FEATURES   = 3'd0;

  // Rule constants
  localparam int TIMER_W = 16;
  localparam int DEB_W   = 6;
  localparam int RE_W    = 14;
  localparam logic [DEB_W-1:0] DEB_NONE = 6'd0;
  localparam logic [DEB_W-1:0] DEB_LINK = 6'd3;
  localparam logic [DEB_W-1:0] DEB_BATT = 6'd3;
  localparam logic [DEB_W-1:0] DEB_GPS  = 6'd60;
  localparam logic [DEB_W-1:0] DEB_FUEL = 6'd12;
  localparam logic [TIMER_W-1:0] ICE_HIDE_AT = 16'd10;
  localparam logic [15:0] NMEA_MIN = 16'd100;

  localparam int SERVICE_KM_DEF    = 15000;
  localparam int SERVICE_HOURS_DEF = 500;

  typedef struct packed {
    logic               active;
    logic               hidden;
    logic [TIMER_W-1:0] timer;
  } chan_t;

  // Saturating timer add
  function automatic logic [TIMER_W-1:0] timer_add(logic [TIMER_W-1:0] t,
                                                   logic [2:0] n);
    logic [TIMER_W:0] s;
    s = {1'b0, t} + {{(TIMER_W-2){1'b0}}, n};
    return s[TIMER_W] ? {TIMER_W{1'b1}} : s[TIMER_W-1:0];
  endfunction

  // Condition present: re-show when active, else debounce
  function automatic chan_t persist(chan_t c, logic [DEB_W-1:0] deb,
                                    logic [RE_W-1:0] re_secs);
    chan_t r;
    logic [TIMER_W-1:0] t;
    r = c;
    if (c.active) begin
      t = timer_add(c.timer, 3'd5);
      if (t > {{(TIMER_W-RE_W){1'b0}}, re_secs}) begin
        r.hidden = 1'b0;
        r.timer  = '0;
      end else begin
        r.timer = t;
      end
    end else if (deb == DEB_NONE) begin
      r.active = 1'b1;
      r.timer  = '0;
    end else begin
      t = timer_add(c.timer, 3'd1);
      if (t > {{(TIMER_W-DEB_W){1'b0}}, deb}) begin
        r.active = 1'b1;
        r.timer  = '0;
      end else begin
        r.timer = t;
      end
    end
    return r;
  endfunction

  function automatic chan_t clear_chan();
    chan_t r;
    r.active = 1'b0;
    r.hidden = 1'b0;
    r.timer  = '0;
    return r;
  endfunction

  // Lowest-numbered shown channel, TOP_NONE if none
  function automatic logic [CH_IDX_W-1:0] first_shown(
      logic [NUM_CHANNELS-1:0] shown);
    logic [CH_IDX_W-1:0] r;
    r = TOP_NONE;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (shown[i]) r = CH_IDX_W'(i);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/vehicle_warning_monitor.sv @@
// Vehicle warning monitor: nine warning channels, several with debounce and re-show timers.
// Depends on vwm_pkg for channel types, codes and rule functions.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item: a five-second tick
//   with vehicle readings, a short button press (hide the top warning) or a
//   long press (clear it). Output channel (out_valid / out_stall) returns one
//   result per item: active and hidden masks, the top shown warning, the
//   any_warning flag, an alarm_start pulse and the dismissed flag.
//   The result is registered: an item transferred at a clock edge is shown at
//   the output from that edge onward. Throughput is one item per cycle while
//   the receiver does not stall; the channel state update and the output
//   register both sit behind combinational compares and small adds.
//   When the receiver stalls, the result register holds and in_stall rises,
//   so no new item is taken until the result is transferred.
//   Configuration is a plain write port (cfg_write, cfg_index, cfg_data); the user
//   must write it only while the block is idle; the block does not enforce this.
//   Reset (rst, synchronous) clears all channels, the indication flag and the
//   output valid, and loads the default limits.
module vehicle_warning_monitor
  import vwm_pkg::*;
#(
  parameter int SERVICE_KM    = SERVICE_KM_DEF,
  parameter int SERVICE_HOURS = SERVICE_HOURS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            action,
  input  logic [6:0]            status_flags,
  input  logic signed [8:0]     engine_temp,
  input  logic signed [8:0]     trans_temp,
  input  logic [14:0]           battery_mv,
  input  logic signed [6:0]     outside_temp,
  input  logic [15:0]           nmea_count,
  input  logic [31:0]           service_meters,
  input  logic [31:0]           service_seconds,
  input  logic [9:0]            fuel_reading,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  any_warning,
  output logic                  alarm_start,
  output logic [CH_IDX_W-1:0]   top_warning,
  output logic [NUM_CHANNELS-1:0] active_mask,
  output logic [NUM_CHANNELS-1:0] hidden_mask,
  output logic                  dismissed
);

  localparam logic [31:0] SERVICE_M_LIM = 32'(SERVICE_KM * 1000);
  localparam logic [31:0] SERVICE_S_LIM = 32'(SERVICE_HOURS * 3600);

  // Configuration registers
  logic [7:0]  realert_minutes;
  logic [7:0]  engine_temp_limit;
  logic [7:0]  trans_temp_limit;
  logic [14:0] battery_high_mv;
  logic [14:0] battery_low_mv;
  logic [6:0]  outside_temp_limit;
  logic [9:0]  fuel_low_limit;
  logic [2:0]  feature_enables;

  // Channel state
  chan_t chan      [NUM_CHANNELS];
  chan_t chan_next [NUM_CHANNELS];
  logic  indication_on;

  logic in_accept;
  logic out_valid_next;
  logic dismissed_next;
  logic [NUM_CHANNELS-1:0] act_cur, hid_cur, act_new, hid_new;
  logic [CH_IDX_W-1:0] top_cur, top_new;
  logic any_new;
  logic [RE_W-1:0] re_secs;

  // Reading compares
  logic signed [10:0] et_s, tt_s, elim_s, tlim_s;
  logic signed [16:0] mv_s, hi_s, lo_s;
  logic signed [8:0]  ot_s, olim_s;
  logic eng_hot, eng_cool, trans_hot, trans_cool;
  logic batt_out, batt_in, ice_cold, ice_warm;
  logic gps_bad, serv_due, fuel_low;

  // Handshake
  assign in_stall       = out_valid & out_stall;
  assign in_accept      = in_valid & ~in_stall;
  assign out_valid_next = in_accept | (out_valid & out_stall);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      realert_minutes    <= RST_REALERT;
      engine_temp_limit  <= RST_ENG_LIMIT;
      trans_temp_limit   <= RST_TRANS_LIM;
      battery_high_mv    <= RST_BATT_HIGH;
      battery_low_mv     <= RST_BATT_LOW;
      outside_temp_limit <= RST_OUT_LIMIT;
      fuel_low_limit     <= RST_FUEL_LIMIT;
      feature_enables    <= RST_FEATURES;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_REALERT:    realert_minutes    <= cfg_data[7:0];
        REG_ENG_LIMIT:  engine_temp_limit  <= cfg_data[7:0];
        REG_TRANS_LIM:  trans_temp_limit   <= cfg_data[7:0];
        REG_BATT_HIGH:  battery_high_mv    <= cfg_data[14:0];
        REG_BATT_LOW:   battery_low_mv     <= cfg_data[14:0];
        REG_OUT_LIMIT:  outside_temp_limit <= cfg_data[6:0];
        REG_FUEL_LIMIT: fuel_low_limit     <= cfg_data[9:0];
        REG_FEATURES:   feature_enables    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Re-show interval in seconds
  assign re_secs = RE_W'({6'd0, realert_minutes} * 14'd60);

  // Sign-extend temperatures and the outside limit, zero-extend the rest to common widths
  assign et_s   = {{2{engine_temp[8]}}, engine_temp};
  assign tt_s   = {{2{trans_temp[8]}}, trans_temp};
  assign elim_s = {3'b000, engine_temp_limit};
  assign tlim_s = {3'b000, trans_temp_limit};
  assign mv_s   = {2'b00, battery_mv};
  assign hi_s   = {2'b00, battery_high_mv};
  assign lo_s   = {2'b00, battery_low_mv};
  assign ot_s   = {{2{outside_temp[6]}}, outside_temp};
  assign olim_s = {{2{outside_temp_limit[6]}}, outside_temp_limit};

  assign eng_hot    = et_s > elim_s;
  assign eng_cool   = et_s < (elim_s - 11'sd3);
  assign trans_hot  = tt_s > tlim_s;
  assign trans_cool = tt_s < (tlim_s - 11'sd3);
  assign batt_out   = (battery_mv > battery_high_mv) || (battery_mv < battery_low_mv);
  assign batt_in    = (mv_s < (hi_s - 17'sd400)) && (mv_s > (lo_s + 17'sd400));
  assign ice_cold   = ot_s < olim_s;
  assign ice_warm   = ot_s > (olim_s + 9'sd3);
  assign gps_bad    = (nmea_count < NMEA_MIN) || !status_flags[ST_GPS_FIX];
  assign serv_due   = (service_meters > SERVICE_M_LIM) || (service_seconds > SERVICE_S_LIM);
  assign fuel_low   = fuel_reading < fuel_low_limit;

  // Current masks and top warning
  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      act_cur[i] = chan[i].active;
      hid_cur[i] = chan[i].hidden;
    end
  end
  assign top_cur = first_shown(act_cur & ~hid_cur);

  // Channel next state for one item
  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) chan_next[i] = chan[i];
    dismissed_next = 1'b0;
    case (action_t'(action))
      ACT_TICK: begin
        if (!status_flags[ST_LINK_UP]) begin
          // link down: only the link channel advances
          chan_next[CH_LINK] = persist(chan[CH_LINK], DEB_LINK, re_secs);
        end else begin
          chan_next[CH_LINK] = clear_chan();

          if (status_flags[ST_MIL_ON])
            chan_next[CH_MIL] = persist(chan[CH_MIL], DEB_NONE, re_secs);
          else
            chan_next[CH_MIL] = clear_chan();

          if (eng_hot)
            chan_next[CH_ENG] = persist(chan[CH_ENG], DEB_NONE, re_secs);
          else if (eng_cool)
            chan_next[CH_ENG] = clear_chan();

          if (!status_flags[ST_TRANS_PRES]) begin
            chan_next[CH_TRANS] = clear_chan();
          end else if (status_flags[ST_TRANS_VALID]) begin
            if (trans_hot)
              chan_next[CH_TRANS] = persist(chan[CH_TRANS], DEB_NONE, re_secs);
            else if (trans_cool)
              chan_next[CH_TRANS] = clear_chan();
          end

          if (status_flags[ST_BATT_VALID]) begin
            if (batt_out)
              chan_next[CH_BATT] = persist(chan[CH_BATT], DEB_BATT, re_secs);
            else if (batt_in)
              chan_next[CH_BATT] = clear_chan();
          end

          // ice: self-hides after two ticks while active
          if (!feature_enables[FE_ICE]) begin
            chan_next[CH_ICE] = clear_chan();
          end else if (status_flags[ST_OUT_VALID]) begin
            if (ice_cold) begin
              if (chan[CH_ICE].active) begin
                chan_next[CH_ICE].timer = timer_add(chan[CH_ICE].timer, 3'd5);
                if (chan_next[CH_ICE].timer >= ICE_HIDE_AT)
                  chan_next[CH_ICE].hidden = 1'b1;
              end else begin
                chan_next[CH_ICE].active = 1'b1;
              end
            end else if (ice_warm) begin
              chan_next[CH_ICE] = clear_chan();
            end
          end

          if (feature_enables[FE_GPS] && gps_bad)
            chan_next[CH_GPS] = persist(chan[CH_GPS], DEB_GPS, re_secs);

          if (serv_due && !chan[CH_SERV].active) begin
            chan_next[CH_SERV].active = 1'b1;
            chan_next[CH_SERV].timer  = '0;
          end

          if (feature_enables[FE_FUEL] && fuel_low)
            chan_next[CH_FUEL] = persist(chan[CH_FUEL], DEB_FUEL, re_secs);
        end
      end
      ACT_HIDE: begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (top_cur == CH_IDX_W'(i)) chan_next[i].hidden = 1'b1;
        end
      end
      ACT_CLEAR: begin
        // clear active and hidden of the top channel, keep its timer
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (top_cur == CH_IDX_W'(i)) begin
            chan_next[i].active = 1'b0;
            chan_next[i].hidden = 1'b0;
          end
        end
        dismissed_next = (top_cur != TOP_NONE);
      end
      default: ;
    endcase
  end

  // Result from the updated state
  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      act_new[i] = chan_next[i].active;
      hid_new[i] = chan_next[i].hidden;
    end
  end
  assign top_new = first_shown(act_new & ~hid_new);
  assign any_new = (top_new != TOP_NONE);

  // Advance channel state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) chan[i] <= clear_chan();
      indication_on <= 1'b0;
    end else if (in_accept) begin
      for (int i = 0; i < NUM_CHANNELS; i++) chan[i] <= chan_next[i];
      indication_on <= any_new;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= out_valid_next;
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      any_warning <= any_new;
      alarm_start <= any_new & ~indication_on;
      top_warning <= top_new;
      active_mask <= act_new;
      hidden_mask <= hid_new;
      dismissed   <= dismissed_next;
    end
  end

  // Checks
  a_any_matches_top: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (any_warning == (top_warning != TOP_NONE)))
    else $error("any_warning disagrees with top_warning");

  a_alarm_needs_any: assert property (@(posedge clk) disable iff (rst)
    (out_valid && alarm_start) |-> any_warning)
    else $error("alarm_start without a shown warning");

  a_hidden_only_active: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((hidden_mask & ~active_mask) == '0))
    else $error("hidden bit set on an inactive channel");

  a_state_hidden_active: assert property (@(posedge clk) disable iff (rst)
    (hid_cur & ~act_cur) == '0)
    else $error("channel state hidden without active");

  a_dismiss_clears: assert property (@(posedge clk) disable iff (rst)
    (in_accept && dismissed_next) |=> (act_cur != $past(act_cur)))
    else $error("long press reported dismissal but no channel cleared");

endmodule
